>>> hdl/lca_pkg.sv
// shared types and constants for the life cellular automaton grid
// no dependencies

package lca_pkg;

  localparam int unsigned CoordW = 6;

  localparam logic [3:0] NbrBirth = 4'd3;
  localparam logic [3:0] NbrKeep  = 4'd2;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_STEP = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOOK,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
  } in_t;

  typedef struct packed {
    logic cell_alive;
    logic step_done;
  } out_t;

endpackage

>>> hdl/lca_row_rule.sv
// next-generation row from three neighboring rows, one lane per column
// depends on lca_pkg

module lca_row_rule #(
  parameter int GRID_WIDTH = 64
) (
  input  logic [GRID_WIDTH-1:0] above_i,
  input  logic [GRID_WIDTH-1:0] row_i,
  input  logic [GRID_WIDTH-1:0] below_i,
  output logic [GRID_WIDTH-1:0] next_row_o
);
  import lca_pkg::*;

  for (genvar gx = 0; gx < GRID_WIDTH; gx++) begin : g_cell
    if (gx == 0 || gx == GRID_WIDTH - 1) begin : g_edge
      assign next_row_o[gx] = 1'b0;
    end else begin : g_inner
      logic [3:0] nbr;
      assign nbr = 4'(above_i[gx-1]) + 4'(above_i[gx]) + 4'(above_i[gx+1])
                 + 4'(row_i[gx-1]) + 4'(row_i[gx+1])
                 + 4'(below_i[gx-1]) + 4'(below_i[gx]) + 4'(below_i[gx+1]);
      assign next_row_o[gx] = (nbr == NbrBirth) || (row_i[gx] && (nbr == NbrKeep));
    end
  end

endmodule

>>> hdl/lca_out_reg.sv
// one-entry output register between the sequencer and the result channel
// depends on lca_pkg

module lca_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lca_pkg::out_t data_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lca_pkg::out_t out_data_o
);
  import lca_pkg::*;

  logic valid_q;
  out_t data_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

endmodule

>>> hdl/lca_ctrl.sv
// grid row memory with its sequencer: clearing pass, set/read access and
// the generation sweep through a three-row window; depends on lca_pkg, lca_row_rule

module lca_ctrl #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          run_enable_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lca_pkg::in_t  in_data_i,
  output logic          res_push_o,
  output lca_pkg::out_t res_data_o,
  input  logic          res_space_i
);
  import lca_pkg::*;

  localparam int RowAw = $clog2(GRID_HEIGHT);
  localparam int ColW  = $clog2(GRID_WIDTH);
  localparam int CntW  = $clog2(GRID_HEIGHT + 2);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic is_set_q, is_step_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [GRID_WIDTH-1:0] win0_q, win1_q;

  logic [GRID_WIDTH-1:0] cell_rows_q [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rdata_q;

  logic                  mem_we, mem_re;
  logic [RowAw-1:0]      mem_waddr, mem_raddr;
  logic [GRID_WIDTH-1:0] mem_wdata;

  logic                  accept, in_grid;
  logic [RowAw-1:0]      row_addr;
  logic [ColW-1:0]       bit_idx;
  logic [GRID_WIDTH-1:0] set_row, rule_row;

  assign accept   = in_valid_i && in_ready_o;
  assign in_grid  = (32'(x_q) < 32'(GRID_WIDTH)) && (32'(y_q) < 32'(GRID_HEIGHT));
  assign row_addr = RowAw'(y_q);
  assign bit_idx  = ColW'(x_q);
  assign set_row  = rdata_q | ({{(GRID_WIDTH-1){1'b0}}, 1'b1} << bit_idx);

  lca_row_rule #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_rule (
    .above_i   (win0_q),
    .row_i     (win1_q),
    .below_i   (rdata_q),
    .next_row_o(rule_row)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_rows_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cell_rows_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_set_q  <= (in_data_i.cmd == CMD_SET);
      is_step_q <= (in_data_i.cmd == CMD_STEP);
      x_q       <= in_data_i.cell_x;
      y_q       <= in_data_i.cell_y;
    end
    if (state_q == ST_STEP && cnt_q != '0 && cnt_q <= CntW'(GRID_HEIGHT)) begin
      win0_q <= win1_q;
      win1_q <= rdata_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(GRID_HEIGHT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (in_data_i.cmd == CMD_STEP && run_enable_i) begin
            state_d = ST_STEP;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_STEP: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(GRID_HEIGHT + 1)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_LOOK;
      ST_LOOK: begin
        if (res_space_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ready_o = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = RowAw'(cnt_q);
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = row_addr;
      end
      ST_LOOK: begin
        if (res_space_i) begin
          res_push_o = 1'b1;
          if (is_set_q && in_grid) begin
            mem_we    = 1'b1;
            mem_waddr = row_addr;
            mem_wdata = set_row;
          end
        end
      end
      ST_STEP: begin
        if (cnt_q < CntW'(GRID_HEIGHT)) begin
          mem_re    = 1'b1;
          mem_raddr = RowAw'(cnt_q);
        end
        if (cnt_q >= CntW'(2)) begin
          mem_we    = 1'b1;
          mem_waddr = RowAw'(cnt_q - CntW'(2));
          // top and bottom rows always die
          if (cnt_q == CntW'(2) || cnt_q == CntW'(GRID_HEIGHT + 1)) begin
            mem_wdata = '0;
          end else begin
            mem_wdata = rule_row;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_data_o.cell_alive = in_grid && (is_set_q || rdata_q[bit_idx]);
  assign res_data_o.step_done  = is_step_q;

endmodule

>>> hdl/life_cellular_automaton_grid_top.sv
// Game of Life (B3/S23) grid held as one row per memory word. After reset a
// clearing pass writes every row dead, during which no command is taken. Set
// and read commands read the addressed row, then push the result (a set also
// writes the row back) once the output register has space. A step with
// run_enable set reads one row per cycle from memory and writes each new row
// back once the row below it has been read, then the addressed row is read for
// the result. A finished result waits in an output register while the next
// command is taken. Border cells are always dead after a step with run_enable set.

module life_cellular_automaton_grid_top #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lca_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lca_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import lca_pkg::*;

  logic run_enable_q;
  logic res_push, res_space;
  out_t res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      run_enable_q <= cfg_wdata_i;
    end
  end

  lca_ctrl #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_enable_i(run_enable_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_push_o  (res_push),
    .res_data_o  (res_data),
    .res_space_i (res_space)
  );

  lca_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_push),
    .data_i     (res_data),
    .space_o    (res_space),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
